@@ rtl/core/rct_pkg.sv @@
`default_nettype none
package rct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_BITS    = 32;
  localparam int MAP_BITS    = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SHIFT_W     = 5;
  localparam int PAGE_MIN    = 12;
  localparam int PAGE_MAX    = 16;

  typedef enum logic [2:0] {
    KIND_RESERVE        = 3'd0,
    KIND_RESERVE_COMMIT = 3'd1,
    KIND_COMMIT         = 3'd2,
    KIND_DECOMMIT       = 3'd3,
    KIND_RELEASE        = 3'd4,
    KIND_CHECK          = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_REGION = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO      = 3'd4,
    ST_NOT_BASE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_SET_MAP
  } cmd_op_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_BITS-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_bad;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_BITS-1:0]  size;
    logic [MAP_BITS-1:0]  map;
  } entry_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [IDX_W-1:0]    target;
    logic [MAP_BITS-1:0] map;
  } cmd_t;

  // pages first..last of a byte range, last clamped to the top page
  function automatic logic [MAP_BITS-1:0] mask_for(input logic [LEN_BITS-1:0] offset,
                                                   input logic [LEN_BITS-1:0] len,
                                                   input logic [SHIFT_W-1:0] shift);
    logic [LEN_BITS:0]   end_off;
    logic [LEN_BITS-1:0] first;
    logic [LEN_BITS:0]   last;
    logic [5:0]          last_c;
    logic [MAP_BITS-1:0] hi;
    logic [MAP_BITS-1:0] lo;
    end_off = {1'b0, offset} + {1'b0, len} - {{LEN_BITS{1'b0}}, 1'b1};
    first   = offset >> shift;
    last    = end_off >> shift;
    last_c  = (last > (LEN_BITS + 1)'(MAP_BITS - 1)) ? 6'(MAP_BITS - 1) : last[5:0];
    hi      = {MAP_BITS{1'b1}} >> (6'(MAP_BITS - 1) - last_c);
    lo      = {MAP_BITS{1'b1}} << first[5:0];
    if (first > LEN_BITS'(MAP_BITS - 1)) begin
      return '0;
    end
    return hi & lo;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/region_commit_tracker.sv @@
`default_nettype none
// path: request registered in S_IDLE, flags in S_CMP, binary search over the cell
// flags in S_SRCH (one probe per cycle, up to 6 probes), then S_GATH, S_MASK, S_APPLY
// throughput: one request in flight; the next is taken once the response is registered
// reset: synchronous, clears the region count and rsp_valid and sets page_shift to 12;
// cell contents are not cleared and only entries below the count are used
module region_commit_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire rct_pkg::req_t                 req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output rct_pkg::rsp_t                      rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rct_pkg::SHIFT_W-1:0]   cfg_data
);
  import rct_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMP   = 6'b000010,
    S_SRCH  = 6'b000100,
    S_GATH  = 6'b001000,
    S_MASK  = 6'b010000,
    S_APPLY = 6'b100000
  } state_t;

  state_t state;

  logic [SHIFT_W-1:0]   page_shift;
  logic [SHIFT_W-1:0]   eff_shift;
  logic [CNT_W-1:0]     count;
  req_t                 cur;

  logic [TABLE_DEPTH-1:0] lt_flags;
  logic [TABLE_DEPTH-1:0] past_flags;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi_end;
  logic                   found;
  logic [IDX_W-1:0]       hit;

  logic [LEN_BITS-1:0] sel_offset;
  logic [LEN_BITS-1:0] sel_size;
  logic [MAP_BITS-1:0] sel_map;
  logic                sel_at_base;
  logic [MAP_BITS-1:0] mask;
  logic                fits;

  entry_t              ents    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt_v;
  logic [TABLE_DEPTH-1:0] past_v;
  logic [TABLE_DEPTH-1:0] base_v;
  logic [LEN_BITS-1:0] off_v   [TABLE_DEPTH];

  cmd_t                cmd;
  logic [CNT_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [LEN_BITS-1:0] g_offset;
  logic [LEN_BITS-1:0] g_size;
  logic [MAP_BITS-1:0] g_map;
  logic                g_at_base;
  logic                len_zero;
  logic [2:0]          status_next;
  logic                bad_next;
  logic [CNT_W-1:0]    count_next;
  logic                slot_free;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;
  assign len_zero  = (cur.length == '0);

  assign eff_shift = (page_shift < SHIFT_W'(PAGE_MIN)) ? SHIFT_W'(PAGE_MIN) :
                     (page_shift > SHIFT_W'(PAGE_MAX)) ? SHIFT_W'(PAGE_MAX) : page_shift;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_g;
    if (k == 0) begin : g_first
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[k-1];
      assign prev_g = gt_v[k-1];
    end
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign next_e = ents[k];
    end else begin : g_inner
      assign next_e = ents[k+1];
    end
    rct_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(k)),
      .count      (count),
      .address    (cur.address),
      .length     (cur.length),
      .cmd        (cmd),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .entry      (ents[k]),
      .gt         (gt_v[k]),
      .past       (past_v[k]),
      .at_base    (base_v[k]),
      .offset     (off_v[k])
    );
  end

  // binary search probe
  assign mid_sum = {1'b0, lo} + {1'b0, hi_end} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];

  // pick out the hit cell
  always_comb begin
    g_offset  = '0;
    g_size    = '0;
    g_map     = '0;
    g_at_base = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (found && hit == IDX_W'(k)) begin
        g_offset  = g_offset | off_v[k];
        g_size    = g_size | ents[k].size;
        g_map     = g_map | ents[k].map;
        g_at_base = g_at_base | base_v[k];
      end
    end
  end

  always_comb begin
    cmd         = '{op: CMD_NONE, target: hit, map: '0};
    status_next = ST_OK;
    bad_next    = 1'b0;
    count_next  = count;
    case (cur.kind)
      KIND_RESERVE, KIND_RESERVE_COMMIT: begin
        if (len_zero) begin
          status_next = ST_ZERO;
        end else if (count >= CNT_W'(TABLE_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          cmd.op     = CMD_INSERT;
          cmd.map    = (cur.kind == KIND_RESERVE_COMMIT) ? mask : '0;
          count_next = count + CNT_W'(1);
        end
      end
      KIND_COMMIT: begin
        if (len_zero) begin
          status_next = ST_ZERO;
        end else if (!found) begin
          status_next = ST_NO_REGION;
        end else if (!fits) begin
          status_next = ST_OUTSIDE;
        end else begin
          cmd.op  = CMD_SET_MAP;
          cmd.map = sel_map | mask;
        end
      end
      KIND_DECOMMIT: begin
        if (!found) begin
          status_next = ST_NO_REGION;
        end else if (len_zero) begin
          status_next = ST_ZERO;
        end else if (!fits) begin
          status_next = ST_OUTSIDE;
        end else begin
          cmd.op  = CMD_SET_MAP;
          cmd.map = sel_map & ~mask;
        end
      end
      KIND_RELEASE: begin
        if (!found) begin
          status_next = ST_NO_REGION;
        end else if (!sel_at_base) begin
          status_next = ST_NOT_BASE;
        end else begin
          cmd.op     = CMD_REMOVE;
          count_next = count - CNT_W'(1);
        end
      end
      KIND_CHECK: begin
        bad_next = (cur.address == '0) || len_zero || !found || !fits ||
                   ((sel_map & mask) != mask);
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (state != S_APPLY || !slot_free) begin
      cmd.op = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      page_shift <= SHIFT_W'(PAGE_MIN);
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        page_shift <= cfg_data;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (found || lo >= hi_end) begin
            state <= S_GATH;
          end
        end
        S_GATH: begin
          state <= S_MASK;
        end
        S_MASK: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (slot_free) begin
            count     <= count_next;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload, search, gather, mask and response registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur <= req;
        end
      end
      S_CMP: begin
        lt_flags   <= gt_v;
        past_flags <= past_v;
        lo         <= '0;
        hi_end     <= count;
        found      <= 1'b0;
        hit        <= '0;
      end
      S_SRCH: begin
        if (!found && lo < hi_end) begin
          if (lt_flags[mid]) begin
            hi_end <= CNT_W'(mid);
          end else if (past_flags[mid]) begin
            lo <= CNT_W'(mid) + CNT_W'(1);
          end else begin
            found <= 1'b1;
            hit   <= mid;
          end
        end
      end
      S_GATH: begin
        sel_offset  <= g_offset;
        sel_size    <= g_size;
        sel_map     <= g_map;
        sel_at_base <= g_at_base;
      end
      S_MASK: begin
        // reserve and reserve-commit mask the new region from offset zero, clamped to the top page
        if (cur.kind == KIND_RESERVE || cur.kind == KIND_RESERVE_COMMIT) begin
          mask <= mask_for('0, cur.length, eff_shift);
        end else begin
          mask <= mask_for(sel_offset, cur.length, eff_shift);
        end
        fits <= ({1'b0, sel_offset} + {1'b0, cur.length}) <= {1'b0, sel_size};
      end
      S_APPLY: begin
        if (slot_free) begin
          rsp.status <= status_next;
          rsp.is_bad <= bad_next;
        end
      end
      default: begin
        fits <= fits;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/rct_cell.sv @@
`default_nettype none
module rct_cell (
  input  wire logic                          clk,
  input  wire logic [rct_pkg::IDX_W-1:0]     idx,
  input  wire logic [rct_pkg::CNT_W-1:0]     count,
  input  wire logic [rct_pkg::ADDR_BITS-1:0] address,
  input  wire logic [rct_pkg::LEN_BITS-1:0]  length,
  input  wire rct_pkg::cmd_t                 cmd,
  input  wire rct_pkg::entry_t               prev_entry,
  input  wire logic                          prev_gt,
  input  wire rct_pkg::entry_t               next_entry,
  output rct_pkg::entry_t                    entry,
  output logic                               gt,
  output logic                               past,
  output logic                               at_base,
  output logic [rct_pkg::LEN_BITS-1:0]       offset
);
  import rct_pkg::*;

  entry_t               entry_next;
  logic                 valid;
  logic [ADDR_BITS-1:0] diff;

  assign valid   = CNT_W'(idx) < count;
  assign gt      = valid && (entry.base > address);
  assign diff    = address - entry.base;
  assign past    = diff >= ADDR_BITS'(entry.size);
  assign at_base = (diff == '0);
  assign offset  = diff[LEN_BITS-1:0];

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CMD_INSERT: begin
        // entries above the new base move up one cell
        if (idx != '0 && prev_gt) begin
          entry_next = prev_entry;
        end else if (CNT_W'(idx) == count || gt) begin
          entry_next.base = address;
          entry_next.size = length;
          entry_next.map  = cmd.map;
        end
      end
      CMD_REMOVE: begin
        if (valid && idx >= cmd.target) begin
          entry_next = next_entry;
        end
      end
      CMD_SET_MAP: begin
        if (idx == cmd.target) begin
          entry_next.map = cmd.map;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire
